FILE: hdl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg: shared types and constants of the generational handle allocator
// Request and status codes, item structs, memory entry layouts and the
// generation increment helper.
// ----------------------------------------------------------------------------
package gha_pkg;

    // Table geometry.
    localparam int SLOT_COUNT = 1024;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W      = IDX_W + 1;
    localparam int GEN_BITS   = 16;

    // Request codes; the unused code behaves as a check.
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_CHECK   = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_STALE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Input item.
    typedef struct packed {
        logic [1:0]          req_type;
        logic [IDX_W-1:0]    slot_index;
        logic [GEN_BITS-1:0] handle_generation;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [IDX_W-1:0]    result_index;
        logic [GEN_BITS-1:0] result_generation;
        logic                handle_live;
        logic [1:0]          status;
    } t_out_item;

    // One slot of the generation table.
    typedef struct packed {
        logic                alive;
        logic [GEN_BITS-1:0] generation;
    } t_slot_entry;

    // One free stack entry: the index and the generation it was left with.
    typedef struct packed {
        logic [IDX_W-1:0]    index;
        logic [GEN_BITS-1:0] generation;
    } t_stack_entry;

    // Generation increment that wraps and skips zero.
    function automatic logic [GEN_BITS-1:0] gen_next(input logic [GEN_BITS-1:0] g);
        logic [GEN_BITS-1:0] n;
        n = g + {{(GEN_BITS-1){1'b0}}, 1'b1};
        return (n == '0) ? {{(GEN_BITS-1){1'b0}}, 1'b1} : n;
    endfunction

endpackage

FILE: hdl/gha_ram.sv
// ----------------------------------------------------------------------------
// gha_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/generational_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit: slot table handing out index/generation
// handles. Each item is accepted in S_IDLE, where the slot table and the free
// stack are read, and is decided and written back in S_EXEC. A new item is
// taken only once the last one has left S_EXEC; the result register lets the
// next item in while a result waits. Synchronous active-low reset clears the
// counters and the control state only; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
module generational_handle_allocator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gha_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gha_pkg::t_out_item o_out_item
);
    import gha_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state       r_state, n_state;
    t_in_item     r_req;
    logic [CNT_W-1:0] r_free_count, n_free_count;
    logic [CNT_W-1:0] r_slots_used, n_slots_used;
    logic         r_out_valid, n_out_valid;
    t_out_item    r_out, n_out;

    logic         in_accept;
    logic         exec_go;
    logic         slot_we;
    logic [IDX_W-1:0] slot_waddr;
    t_slot_entry  slot_wdata;
    t_slot_entry  slot_rdata;
    logic         stack_we;
    logic [IDX_W-1:0] stack_waddr;
    t_stack_entry stack_wdata;
    t_stack_entry stack_rdata;
    logic [CNT_W-1:0] stack_top;
    logic         req_live;
    logic [GEN_BITS-1:0] gen_after;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign exec_go   = (r_state == S_EXEC) && !(r_out_valid && i_out_stall);
    assign stack_top = r_free_count - {{(CNT_W-1){1'b0}}, 1'b1};

    // Slot table: alive mark and generation per slot.
    gha_ram #(
        .WIDTH($bits(t_slot_entry)),
        .DEPTH(SLOT_COUNT)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(slot_waddr),
        .i_wdata(slot_wdata),
        .i_re   (in_accept),
        .i_raddr(i_in_item.slot_index),
        .o_rdata(slot_rdata)
    );

    // Free stack of released slots with their stored generation.
    gha_ram #(
        .WIDTH($bits(t_stack_entry)),
        .DEPTH(SLOT_COUNT)
    ) u_stack_ram (
        .i_clk  (i_clk),
        .i_we   (stack_we),
        .i_waddr(stack_waddr),
        .i_wdata(stack_wdata),
        .i_re   (in_accept),
        .i_raddr(stack_top[IDX_W-1:0]),
        .o_rdata(stack_rdata)
    );

    // Liveness of the requested handle; slots at or above the fill count
    // were never written and are not looked at.
    assign req_live = (r_req.handle_generation != '0)
                   && ({1'b0, r_req.slot_index} < r_slots_used)
                   && slot_rdata.alive
                   && (slot_rdata.generation == r_req.handle_generation);
    assign gen_after = gen_next(r_req.handle_generation);

    // Decide the request and build the write-backs and the result.
    always_comb begin
        n_free_count = r_free_count;
        n_slots_used = r_slots_used;
        slot_we      = 1'b0;
        slot_waddr   = r_req.slot_index;
        slot_wdata   = '{alive: 1'b0, generation: gen_after};
        stack_we     = 1'b0;
        stack_waddr  = r_free_count[IDX_W-1:0];
        stack_wdata  = '{index: r_req.slot_index, generation: gen_after};
        n_out        = '{result_index:      r_req.slot_index,
                         result_generation: r_req.handle_generation,
                         handle_live:       1'b0,
                         status:            ST_OK};
        unique case (r_req.req_type)
            REQ_ALLOC: begin
                if (r_free_count != '0) begin
                    // Reuse the most recently released slot.
                    slot_we      = exec_go;
                    slot_waddr   = stack_rdata.index;
                    slot_wdata   = '{alive: 1'b1,
                                     generation: gen_next(stack_rdata.generation)};
                    n_free_count = exec_go ? stack_top : r_free_count;
                    n_out.result_index      = stack_rdata.index;
                    n_out.result_generation = gen_next(stack_rdata.generation);
                    n_out.handle_live       = 1'b1;
                end else if (r_slots_used < CNT_W'(SLOT_COUNT)) begin
                    // Take the next slot that was never used.
                    slot_we      = exec_go;
                    slot_waddr   = r_slots_used[IDX_W-1:0];
                    slot_wdata   = '{alive: 1'b1,
                                     generation: {{(GEN_BITS-1){1'b0}}, 1'b1}};
                    n_slots_used = exec_go ? r_slots_used + {{(CNT_W-1){1'b0}}, 1'b1}
                                           : r_slots_used;
                    n_out.result_index      = r_slots_used[IDX_W-1:0];
                    n_out.result_generation = {{(GEN_BITS-1){1'b0}}, 1'b1};
                    n_out.handle_live       = 1'b1;
                end else begin
                    n_out.result_index      = '0;
                    n_out.result_generation = '0;
                    n_out.status            = ST_FULL;
                end
            end
            REQ_RELEASE: begin
                if (req_live) begin
                    slot_we = exec_go;
                    if (r_free_count < CNT_W'(SLOT_COUNT)) begin
                        stack_we     = exec_go;
                        n_free_count = exec_go ? r_free_count + {{(CNT_W-1){1'b0}}, 1'b1}
                                               : r_free_count;
                    end
                    n_out.handle_live = 1'b1;
                end else begin
                    n_out.status = ST_STALE;
                end
            end
            default: begin
                // Check, and the unused code treated as a check.
                n_out.handle_live = req_live;
            end
        endcase
    end

    // Sequencer and output register handshake.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_go) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_count <= '0;
            r_slots_used <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_count <= n_free_count;
            r_slots_used <= n_slots_used;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_in_item;
        end
        if (exec_go) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // The free stack never holds more slots than have been handed out.
    a_free_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= r_slots_used)
        else $error("free count exceeds used slot count");

    // A push never runs past the stack depth.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stack_we |-> (r_free_count < CNT_W'(SLOT_COUNT)))
        else $error("free stack push while full");

    // An accepted item enters the execute state in the following cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EXEC))
        else $error("accepted item not executed");

    // A new result only appears after an execute cycle.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result without execution");

endmodule
